### src/cau_pkg.sv
// Shared types, constants and saturation helpers for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int W  = 32;
  localparam int F  = 24;
  localparam int EW = 16;
  localparam int PW = 2 * W;
  localparam int AW = PW + 2;
  localparam int CW = $clog2(W);

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_POW   = 3'd4;
  localparam logic [2:0] OP_MODSQ = 3'd5;
  localparam logic [2:0] OP_MOD   = 3'd6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_V = W'(1) << F;
  localparam logic signed [AW-1:0] HALF_V = AW'(1) << (F - 1);

  typedef struct packed {
    logic [2:0]          opcode;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
    logic [EW-1:0]       exponent;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] res_re;
    logic signed [W-1:0] res_im;
    logic [1:0]          status;
  } out_t;

  typedef enum logic [3:0] {
    M_AR_BR, M_AI_BI, M_AR_BI, M_AI_BR,
    M_PR_AR, M_PI_AI, M_PR_AI, M_PI_AR,
    M_AR_AR, M_AI_AI, M_BR_BR, M_BI_BI
  } msel_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    msel_t   msel;
    acc_op_t acc_op;
    logic    save_re;
    logic    save_im;
    logic    addsub;
    logic    sub;
    logic    pow_upd;
    logic    den_save;
    logic    set_dz;
    logic    div_init;
    logic    div_step;
    logic    div_save;
    logic    div_im;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    sqrt_save;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
  } stat_t;

  typedef struct packed {
    logic                ovf;
    logic signed [W-1:0] val;
  } sat_t;

  function automatic sat_t sat_wide(input logic signed [AW-1:0] x);
    sat_t r;
    logic ok;
    ok = (&x[AW-1:W-1]) || !(|x[AW-1:W-1]);
    r.ovf = !ok;
    r.val = ok ? x[W-1:0] : (x[AW-1] ? MIN_V : MAX_V);
    return r;
  endfunction

  // Round to nearest, ties upward, then drop the fraction bits and saturate.
  function automatic sat_t sat_rnd(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] t;
    t = (x + HALF_V) >>> F;
    return sat_wide(t);
  endfunction

endpackage
`default_nettype wire

### src/cau_datapath.sv
// Datapath: operand registers, shared multiplier, accumulator and divide/root iteration.
`default_nettype none
module cau_datapath (
  input  wire logic          clk,
  input  wire cau_pkg::in_t  in_data,
  input  wire cau_pkg::cmd_t cmd,
  output cau_pkg::stat_t     stat,
  output cau_pkg::out_t      out_data
);

  localparam int W  = cau_pkg::W;
  localparam int F  = cau_pkg::F;
  localparam int PW = cau_pkg::PW;
  localparam int AW = cau_pkg::AW;

  logic signed [W-1:0]  a_re_r, a_im_r, b_re_r, b_im_r, p_re_r, p_im_r;
  logic signed [W-1:0]  res_re_r, res_im_r;
  logic [1:0]           st_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic [PW-1:0]        den_r, rem_r, sh_r;
  logic [W-1:0]         q_r;
  logic                 neg_r, povf_r;
  cau_pkg::out_t        out_r;

  logic signed [W-1:0]  mx, my;
  logic signed [AW-1:0] pext;
  logic [PW-1:0]        mag;
  logic [PW:0]          dr2;
  logic                 dge;
  logic [PW-1:0]        sr2, trial;
  logic                 sge;
  cau_pkg::sat_t        s_rnd, s_re, s_im, s_div, s_sqrt;

  always_comb begin
    case (cmd.msel)
      cau_pkg::M_AR_BR: begin mx = a_re_r; my = b_re_r; end
      cau_pkg::M_AI_BI: begin mx = a_im_r; my = b_im_r; end
      cau_pkg::M_AR_BI: begin mx = a_re_r; my = b_im_r; end
      cau_pkg::M_AI_BR: begin mx = a_im_r; my = b_re_r; end
      cau_pkg::M_PR_AR: begin mx = p_re_r; my = a_re_r; end
      cau_pkg::M_PI_AI: begin mx = p_im_r; my = a_im_r; end
      cau_pkg::M_PR_AI: begin mx = p_re_r; my = a_im_r; end
      cau_pkg::M_PI_AR: begin mx = p_im_r; my = a_re_r; end
      cau_pkg::M_AR_AR: begin mx = a_re_r; my = a_re_r; end
      cau_pkg::M_AI_AI: begin mx = a_im_r; my = a_im_r; end
      cau_pkg::M_BR_BR: begin mx = b_re_r; my = b_re_r; end
      cau_pkg::M_BI_BI: begin mx = b_im_r; my = b_im_r; end
      default:          begin mx = a_re_r; my = b_re_r; end
    endcase
  end

  assign pext  = AW'(prod_r);
  assign s_rnd = cau_pkg::sat_rnd(acc_r);
  assign s_re  = cau_pkg::sat_wide(cmd.sub ? AW'(a_re_r) - AW'(b_re_r)
                                           : AW'(a_re_r) + AW'(b_re_r));
  assign s_im  = cau_pkg::sat_wide(cmd.sub ? AW'(a_im_r) - AW'(b_im_r)
                                           : AW'(a_im_r) + AW'(b_im_r));
  assign mag   = acc_r[AW-1] ? PW'(-acc_r) : PW'(acc_r);

  // Restoring division step: one quotient bit per cycle.
  assign dr2 = {rem_r, sh_r[W-1]};
  assign dge = dr2 >= {1'b0, den_r};

  // Digit-by-digit square root: two radicand bits per cycle.
  assign sr2   = {rem_r[PW-3:0], sh_r[PW-1:PW-2]};
  assign trial = PW'({q_r, 2'b01});
  assign sge   = sr2 >= trial;

  always_comb begin
    if (!neg_r) begin
      s_div.ovf = povf_r || q_r[W-1];
      s_div.val = s_div.ovf ? cau_pkg::MAX_V : q_r;
    end else begin
      s_div.ovf = povf_r || (q_r > cau_pkg::MIN_V);
      s_div.val = s_div.ovf ? cau_pkg::MIN_V : W'(-q_r);
    end
    s_sqrt.ovf = q_r[W-1];
    s_sqrt.val = q_r[W-1] ? cau_pkg::MAX_V : q_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_re_r   <= in_data.a_re;
      a_im_r   <= in_data.a_im;
      b_re_r   <= in_data.b_re;
      b_im_r   <= in_data.b_im;
      p_re_r   <= cau_pkg::ONE_V;
      p_im_r   <= '0;
      res_re_r <= (in_data.opcode == cau_pkg::OP_POW) ? cau_pkg::ONE_V : '0;
      res_im_r <= '0;
      st_r     <= cau_pkg::ST_OK;
    end
    if (cmd.mul_en) begin
      prod_r <= PW'(mx) * PW'(my);
    end
    case (cmd.acc_op)
      cau_pkg::ACC_LOAD: acc_r <= pext;
      cau_pkg::ACC_ADD:  acc_r <= acc_r + pext;
      cau_pkg::ACC_SUB:  acc_r <= acc_r - pext;
      default:           acc_r <= acc_r;
    endcase
    if (cmd.save_re) begin
      res_re_r <= s_rnd.val;
      st_r     <= st_r | {1'b0, s_rnd.ovf};
    end
    if (cmd.save_im) begin
      res_im_r <= s_rnd.val;
      st_r     <= st_r | {1'b0, s_rnd.ovf};
    end
    if (cmd.addsub) begin
      res_re_r <= s_re.val;
      res_im_r <= s_im.val;
      st_r     <= st_r | {1'b0, s_re.ovf | s_im.ovf};
    end
    if (cmd.pow_upd) begin
      p_re_r <= res_re_r;
      p_im_r <= res_im_r;
    end
    if (cmd.den_save) begin
      den_r <= acc_r[PW-1:0];
    end
    if (cmd.set_dz) begin
      res_re_r <= '0;
      res_im_r <= '0;
      st_r     <= cau_pkg::ST_DZ;
    end
    if (cmd.div_init) begin
      neg_r  <= acc_r[AW-1];
      povf_r <= (mag >> (W - F)) >= den_r;
      rem_r  <= mag >> (W - F);
      sh_r   <= PW'({mag[W-F-1:0], {F{1'b0}}});
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= dge ? PW'(dr2 - {1'b0, den_r}) : PW'(dr2);
      q_r   <= {q_r[W-2:0], dge};
      sh_r  <= sh_r << 1;
    end
    if (cmd.div_save) begin
      if (cmd.div_im) begin
        res_im_r <= s_div.val;
      end else begin
        res_re_r <= s_div.val;
      end
      st_r <= st_r | {1'b0, s_div.ovf};
    end
    if (cmd.sqrt_init) begin
      sh_r  <= acc_r[PW-1:0];
      rem_r <= '0;
      q_r   <= '0;
    end
    if (cmd.sqrt_step) begin
      rem_r <= sge ? sr2 - trial : sr2;
      q_r   <= {q_r[W-2:0], sge};
      sh_r  <= sh_r << 2;
    end
    if (cmd.sqrt_save) begin
      res_re_r <= s_sqrt.val;
      st_r     <= st_r | {1'b0, s_sqrt.ovf};
    end
    if (cmd.out_load) begin
      out_r.res_re <= res_re_r;
      out_r.res_im <= res_im_r;
      out_r.status <= st_r;
    end
  end

  assign stat.den_zero = (den_r == '0);
  assign out_data      = out_r;

endmodule
`default_nettype wire

### src/cau_ctrl.sv
// Controller: sequences products, divide and root iterations, and the output handshake.
`default_nettype none
module cau_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire cau_pkg::in_t   in_data,
  input  wire logic           out_ready,
  input  wire cau_pkg::stat_t stat,
  output logic                in_ready,
  output logic                out_valid,
  output cau_pkg::cmd_t       cmd
);

  localparam int W  = cau_pkg::W;
  localparam int EW = cau_pkg::EW;
  localparam int CW = cau_pkg::CW;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_M1, S_M2, S_ACC, S_ACT, S_DZ, S_ITER, S_ISAVE, S_POW, S_OUT
  } state_t;

  typedef enum logic [2:0] {A_RE, A_IM, A_DEN, A_DIV, A_SQRT} act_t;

  state_t         state_r, state_nxt;
  logic [2:0]     op_r, op_nxt;
  logic [1:0]     job_r, job_nxt;
  logic [EW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  it_r, it_nxt;
  logic           out_valid_r, out_valid_nxt;

  cau_pkg::msel_t p1, p2;
  logic           jsub;
  act_t           act;

  // Each job forms acc = p1 +/- p2 and then acts on it.
  always_comb begin
    p1 = cau_pkg::M_AR_AR; p2 = cau_pkg::M_AI_AI; jsub = 1'b0; act = A_RE;
    case (op_r)
      cau_pkg::OP_MUL: begin
        if (job_r == 2'd0) begin
          p1 = cau_pkg::M_AR_BR; p2 = cau_pkg::M_AI_BI; jsub = 1'b1; act = A_RE;
        end else begin
          p1 = cau_pkg::M_AR_BI; p2 = cau_pkg::M_AI_BR; act = A_IM;
        end
      end
      cau_pkg::OP_POW: begin
        if (job_r == 2'd0) begin
          p1 = cau_pkg::M_PR_AR; p2 = cau_pkg::M_PI_AI; jsub = 1'b1; act = A_RE;
        end else begin
          p1 = cau_pkg::M_PR_AI; p2 = cau_pkg::M_PI_AR; act = A_IM;
        end
      end
      cau_pkg::OP_MOD: act = A_SQRT;
      cau_pkg::OP_DIV: begin
        case (job_r)
          2'd0: begin p1 = cau_pkg::M_BR_BR; p2 = cau_pkg::M_BI_BI; act = A_DEN; end
          2'd1: begin p1 = cau_pkg::M_AR_BR; p2 = cau_pkg::M_AI_BI; act = A_DIV; end
          default: begin
            p1 = cau_pkg::M_AI_BR; p2 = cau_pkg::M_AR_BI; jsub = 1'b1; act = A_DIV;
          end
        endcase
      end
      default: act = A_RE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    it_nxt        = it_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.msel      = p1;
    cmd.acc_op    = cau_pkg::ACC_NONE;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          op_nxt   = in_data.opcode;
          cnt_nxt  = in_data.exponent;
          job_nxt  = 2'd0;
          case (in_data.opcode)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: state_nxt = S_ADD;
            cau_pkg::OP_POW: state_nxt = (in_data.exponent == '0) ? S_OUT : S_M1;
            cau_pkg::OP_MUL, cau_pkg::OP_DIV, cau_pkg::OP_MODSQ, cau_pkg::OP_MOD:
              state_nxt = S_M1;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_ADD: begin
        cmd.addsub = 1'b1;
        cmd.sub    = (op_r == cau_pkg::OP_SUB);
        state_nxt  = S_OUT;
      end
      S_M1: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_M2;
      end
      S_M2: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = p2;
        cmd.acc_op = cau_pkg::ACC_LOAD;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_op = jsub ? cau_pkg::ACC_SUB : cau_pkg::ACC_ADD;
        state_nxt  = S_ACT;
      end
      S_ACT: begin
        it_nxt = '0;
        case (act)
          A_RE: begin
            cmd.save_re = 1'b1;
            if (op_r == cau_pkg::OP_MODSQ) begin
              state_nxt = S_OUT;
            end else begin
              job_nxt   = 2'd1;
              state_nxt = S_M1;
            end
          end
          A_IM: begin
            cmd.save_im = 1'b1;
            state_nxt   = (op_r == cau_pkg::OP_POW) ? S_POW : S_OUT;
          end
          A_DEN: begin
            cmd.den_save = 1'b1;
            state_nxt    = S_DZ;
          end
          A_DIV: begin
            cmd.div_init = 1'b1;
            state_nxt    = S_ITER;
          end
          default: begin
            cmd.sqrt_init = 1'b1;
            state_nxt     = S_ITER;
          end
        endcase
      end
      S_DZ: begin
        if (stat.den_zero) begin
          cmd.set_dz = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          job_nxt   = 2'd1;
          state_nxt = S_M1;
        end
      end
      S_ITER: begin
        if (op_r == cau_pkg::OP_DIV) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == CW'(W - 1)) begin
          state_nxt = S_ISAVE;
        end
      end
      S_ISAVE: begin
        if (op_r == cau_pkg::OP_DIV) begin
          cmd.div_save = 1'b1;
          cmd.div_im   = (job_r == 2'd2);
          if (job_r == 2'd1) begin
            job_nxt   = 2'd2;
            state_nxt = S_M1;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          cmd.sqrt_save = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_POW: begin
        cmd.pow_upd = 1'b1;
        cnt_nxt     = cnt_r - 1'b1;
        job_nxt     = 2'd0;
        state_nxt   = (cnt_r == EW'(1)) ? S_OUT : S_M1;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= '0;
      job_r       <= '0;
      cnt_r       <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### src/complex_arithmetic_unit.sv
// The controller sequences each opcode from the accept edge until its result word is valid;
// the shared 32x32 multiplier and the one-bit-per-cycle divide/root iteration set the latency
// of each opcode. A divide ends early on a zero divisor, and power repeats a complex multiply
// once per unit of exponent. One word is in work at a time; the next word can be taken in the
// cycle after a result loads, and a result still held by a stalled receiver stops the unit in
// its last state. Synchronous active-low reset clears the controller and the output valid;
// no other clearing is needed.
`default_nettype none
module complex_arithmetic_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire cau_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output cau_pkg::out_t     out_data
);

  cau_pkg::cmd_t  cmd;
  cau_pkg::stat_t stat;

  cau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cau_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

### src/cau_checker.sv
// Port-level checker for the complex arithmetic unit, bound to the top level.
`default_nettype none
module cau_port_props (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire cau_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire cau_pkg::out_t out_data
);

  // A held result word must not change before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // The unit works on one word at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in work");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= cau_pkg::ST_DZ)
    else $error("undefined status code");

  // A zero divisor returns zero in both parts.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == cau_pkg::ST_DZ |->
      out_data.res_re == '0 && out_data.res_im == '0)
    else $error("zero divisor result not zero");

endmodule

bind complex_arithmetic_unit cau_port_props u_cau_port_props (.*);
`default_nettype wire
